/* sv/bmma_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bmma_pkg;

  // matrix geometry
  localparam int MAX_DIM     = 64;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int DIM_W       = 7;

  // arithmetic widths
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 48;
  localparam int SUM_W  = ACC_W + 2;

  // stream and register port widths
  localparam int S_DATA_W = 32;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 64;
  localparam int APB_A_W  = 3;
  localparam int APB_D_W  = 32;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_BT = 2'd1,
    OP_LOAD_C  = 2'd2,
    OP_COMPUTE = 2'd3
  } opcode_e;

  typedef enum logic {
    REG_ROW_COUNT = 1'b0,
    REG_DIM_SIZE  = 1'b1
  } reg_idx_e;

  // control from the sequencer to the mac datapath
  typedef struct packed {
    logic rd_valid;  // operand read data valid this cycle
    logic init;      // c element read data valid, start a new sum
  } mac_ctrl_t;

endpackage

`default_nettype wire

/* sv/bmma_mac.sv */
`timescale 1ns / 1ps
`default_nettype none

module bmma_mac (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bmma_pkg::mac_ctrl_t           ctrl_i,
  input  wire logic [bmma_pkg::ELEM_W-1:0]   a_i,
  input  wire logic [bmma_pkg::ELEM_W-1:0]   b_i,
  input  wire logic [bmma_pkg::ACC_W-1:0]    c_init_i,
  output logic                               busy_o,
  output logic [bmma_pkg::ACC_W-1:0]         acc_sat_o
);
  import bmma_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_v_q;
  logic signed [SUM_W-1:0]  acc_q;
  logic [SUM_W-ACC_W:0]     acc_top;
  logic                     in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctrl_i.rd_valid;
    end
  end

  // product register, then exact accumulation
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_valid) begin
      prod_q <= $signed(a_i) * $signed(b_i);
    end
    if (ctrl_i.init) begin
      acc_q <= {{(SUM_W-ACC_W){c_init_i[ACC_W-1]}}, c_init_i};
    end else if (prod_v_q) begin
      acc_q <= acc_q + {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // saturate to the accumulator range
  assign acc_top  = acc_q[SUM_W-1:ACC_W-1];
  assign in_range = (&acc_top) || (~|acc_top);

  always_comb begin
    if (in_range) begin
      acc_sat_o = acc_q[ACC_W-1:0];
    end else if (acc_q[SUM_W-1]) begin
      acc_sat_o = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_sat_o = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  assign busy_o = prod_v_q;

endmodule

`default_nettype wire

/* sv/block_matrix_multiply_accumulate_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                  payload
// s_axis    in         s_axis_tvalid/tready       tdata: row_index, col_index, load_value
//                                                 tuser: opcode
// m_axis    out        m_axis_tvalid/tready       tdata: out_row, out_col, out_value
//                                                 tlast: last_of_row
// apb       in         psel, penable, pready      registers row_count (0x0), dim_size (0x4)
//
// a load item writes one entry of a, bt or c
// a compute item of order n makes n reads per column through the single read port of the a
// and bt memories, then drains the pipeline and writes one c element back for each of the n
// columns; each write back waits while the output register holds an unsent element
// reset clears the sequencer, the output valid flag and the registers (64, 64); the
// memories are not cleared and hold garbage until loaded
// the input side is ready only while no row is being computed; the output register
// holds a finished element while the next input item is taken

module block_matrix_multiply_accumulate_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,

  // input items
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [5:0] row_index, [11:6] col_index, [27:12] load_value, [31:28] zero
  input  wire logic [bmma_pkg::S_DATA_W-1:0]    s_axis_tdata,
  // [1:0] opcode
  input  wire logic [bmma_pkg::S_USER_W-1:0]    s_axis_tuser,

  // result items
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [5:0] out_row, [11:6] out_col, [59:12] out_value, [63:60] zero
  output logic [bmma_pkg::M_DATA_W-1:0]         m_axis_tdata,
  output logic                                  m_axis_tlast,

  // register port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bmma_pkg::APB_A_W-1:0]     paddr,
  input  wire logic [bmma_pkg::APB_D_W-1:0]     pwdata,
  output logic [bmma_pkg::APB_D_W-1:0]          prdata,
  output logic                                  pready
);
  import bmma_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_WB    = 4'b1000
  } state_e;

  localparam logic [DIM_W-1:0] MAX_DIM_C = DIM_W'(MAX_DIM);

  state_e state_q, state_d;

  // registers
  logic [DIM_W-1:0] row_count_q, dim_size_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  // input item fields
  opcode_e             in_op;
  logic [IDX_W-1:0]    in_row, in_col;
  logic [ELEM_W-1:0]   in_val;
  logic                in_acc;

  // effective sizes
  logic [DIM_W-1:0] n_eff, rows_eff;
  logic             compute_ok;

  // sequencer
  logic [IDX_W-1:0] cur_row_q, j_q, k_q;
  logic [DIM_W-1:0] n_q;
  logic             k_last, j_last;
  logic             rd_v_q, init_q;
  logic             wb_fire;

  // memories
  logic [ELEM_W-1:0] a_mem  [STORE_DEPTH];
  logic [ELEM_W-1:0] bt_mem [STORE_DEPTH];
  logic [ACC_W-1:0]  c_mem  [STORE_DEPTH];
  logic [ELEM_W-1:0] a_rd_q, bt_rd_q;
  logic [ACC_W-1:0]  c_rd_q;
  logic [ADDR_W-1:0] ld_addr, a_raddr, bt_raddr, c_addr_cur, c_waddr;
  logic [ACC_W-1:0]  c_wdata;
  logic              c_we;

  // mac datapath
  mac_ctrl_t         mac_ctrl;
  logic              mac_busy;
  logic [ACC_W-1:0]  acc_sat;

  // output register
  logic              m_valid_q;
  logic [IDX_W-1:0]  m_row_q, m_col_q;
  logic [ACC_W-1:0]  m_value_q;
  logic              m_last_q;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= MAX_DIM_C;
      dim_size_q  <= MAX_DIM_C;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROW_COUNT: row_count_q <= pwdata[DIM_W-1:0];
        REG_DIM_SIZE:  dim_size_q  <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROW_COUNT: prdata = {{(APB_D_W-DIM_W){1'b0}}, row_count_q};
      REG_DIM_SIZE:  prdata = {{(APB_D_W-DIM_W){1'b0}}, dim_size_q};
      default:       prdata = '0;
    endcase
  end

  // ---------------- input side ----------------
  assign in_op   = opcode_e'(s_axis_tuser[1:0]);
  assign in_row  = s_axis_tdata[IDX_W-1:0];
  assign in_col  = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_val  = s_axis_tdata[2*IDX_W+ELEM_W-1:2*IDX_W];
  assign ld_addr = {in_row, in_col};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // sizes above the store are clamped; zero order or a row past the strip does nothing
  assign n_eff      = (dim_size_q  > MAX_DIM_C) ? MAX_DIM_C : dim_size_q;
  assign rows_eff   = (row_count_q > MAX_DIM_C) ? MAX_DIM_C : row_count_q;
  assign compute_ok = (n_eff != '0) && ({1'b0, in_row} < rows_eff);

  // ---------------- sequencer ----------------
  assign k_last  = ({1'b0, k_q} == (n_q - DIM_W'(1)));
  assign j_last  = ({1'b0, j_q} == (n_q - DIM_W'(1)));
  assign wb_fire = (state_q == ST_WB) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_op == OP_COMPUTE && compute_ok) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (k_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_v_q && !mac_busy) state_d = ST_WB;
      end
      ST_WB: begin
        if (wb_fire) state_d = j_last ? ST_IDLE : ST_RUN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rd_v_q  <= 1'b0;
      init_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= (state_q == ST_RUN);
      init_q  <= (state_q == ST_RUN) && (k_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      n_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          cur_row_q <= in_row;
          n_q       <= n_eff;
          j_q       <= '0;
          k_q       <= '0;
        end
        ST_RUN: begin
          k_q <= k_last ? '0 : k_q + IDX_W'(1);
        end
        ST_WB: begin
          if (wb_fire) j_q <= j_q + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  // ---------------- memories ----------------
  assign a_raddr    = {cur_row_q, k_q};
  assign bt_raddr   = {j_q, k_q};
  assign c_addr_cur = {cur_row_q, j_q};

  // c write: load item or row write back, never in the same cycle
  assign c_we    = (in_acc && in_op == OP_LOAD_C) || wb_fire;
  assign c_waddr = wb_fire ? c_addr_cur : ld_addr;
  assign c_wdata = wb_fire ? acc_sat : {{(ACC_W-ELEM_W){in_val[ELEM_W-1]}}, in_val};

  always_ff @(posedge clk_i) begin
    if (in_acc && in_op == OP_LOAD_A)  a_mem[ld_addr]  <= in_val;
    if (in_acc && in_op == OP_LOAD_BT) bt_mem[ld_addr] <= in_val;
    if (c_we)                          c_mem[c_waddr]  <= c_wdata;
    a_rd_q  <= a_mem[a_raddr];
    bt_rd_q <= bt_mem[bt_raddr];
    c_rd_q  <= c_mem[c_addr_cur];
  end

  // ---------------- mac ----------------
  assign mac_ctrl.rd_valid = rd_v_q;
  assign mac_ctrl.init     = init_q;

  bmma_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mac_ctrl),
    .a_i       (a_rd_q),
    .b_i       (bt_rd_q),
    .c_init_i  (c_rd_q),
    .busy_o    (mac_busy),
    .acc_sat_o (acc_sat)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (wb_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_fire) begin
      m_row_q   <= cur_row_q;
      m_col_q   <= j_q;
      m_value_q <= acc_sat;
      m_last_q  <= j_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {{(M_DATA_W-ACC_W-2*IDX_W){1'b0}}, m_value_q, m_col_q, m_row_q};

endmodule

`default_nettype wire

/* tb/block_matrix_multiply_accumulate_core_tb.sv */
`timescale 1ns / 1ps

module block_matrix_multiply_accumulate_core_tb;
  import bmma_pkg::*;

  localparam int NUM_PHASES   = 15;  // six directed phases, then random ones
  localparam int RAND_ITEMS   = 3;
  localparam longint ACC_HI   = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO   = -(longint'(1) <<< (ACC_W - 1));

  typedef struct packed {
    opcode_e                  op;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic [ELEM_W-1:0]        val;
  } mat_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic [ACC_W-1:0]         value;
    logic                     last;
  } c_elem_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic [S_USER_W-1:0]   s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_A_W-1:0]    paddr = '0;
  logic [APB_D_W-1:0]    pwdata = '0;
  logic [APB_D_W-1:0]    prdata;
  logic                  pready;

  block_matrix_multiply_accumulate_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 4 ns clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #(5_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // matrix state as the block should hold it
  // ---------------------------------------------------------------------------
  logic signed [ELEM_W-1:0] a_mem  [STORE_DEPTH];
  logic signed [ELEM_W-1:0] bt_mem [STORE_DEPTH];
  logic signed [ACC_W-1:0]  c_mem  [STORE_DEPTH];
  logic [DIM_W-1:0]         cfg_rows = 7'd64;
  logic [DIM_W-1:0]         cfg_dim  = 7'd64;

  // entries already loaded, tracked on the stimulus side so that no compute
  // ever reads an entry the block was never given
  bit a_ok  [STORE_DEPTH];
  bit bt_ok [STORE_DEPTH];
  bit c_ok  [STORE_DEPTH];

  mat_cmd_t cmd_q[$];          // items waiting to be driven
  c_elem_t  pending_elems[$];  // c elements the block still owes
  mat_cmd_t drv_cmd;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  int       err_count = 0;

  function automatic int clamp_dim(logic [DIM_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic void note_failure(string msg);
    err_count++;
    if (err_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // apply one accepted item: loads update a store, a compute item produces
  // the new row of c and queues its elements
  task automatic apply_cmd(mat_cmd_t cmd);
    int                       n;
    int                       rows;
    int                       base;
    longint                   acc;
    logic signed [ELEM_W-1:0] sval;
    c_elem_t                  e;
    n    = clamp_dim(cfg_dim);
    rows = clamp_dim(cfg_rows);
    base = int'(cmd.row) * MAX_DIM;
    sval = cmd.val;
    case (cmd.op)
      OP_LOAD_A:  a_mem[base + int'(cmd.col)] = sval;
      OP_LOAD_BT: bt_mem[base + int'(cmd.col)] = sval;
      OP_LOAD_C:  c_mem[base + int'(cmd.col)] = ACC_W'(sval);  // sign extended to 48 bits
      default: begin
        // zero order or a row past the strip leaves everything untouched
        if (n > 0 && int'(cmd.row) < rows) begin
          for (int j = 0; j < n; j++) begin
            acc = longint'(c_mem[base + j]);
            for (int k = 0; k < n; k++)
              acc += longint'(a_mem[base + k]) * longint'(bt_mem[j * MAX_DIM + k]);
            // exact sum, saturated once at the end
            if (acc > ACC_HI) acc = ACC_HI;
            else if (acc < ACC_LO) acc = ACC_LO;
            c_mem[base + j] = acc[ACC_W-1:0];
            e.row   = cmd.row;
            e.col   = j[IDX_W-1:0];
            e.value = acc[ACC_W-1:0];
            e.last  = (j == n - 1);
            pending_elems.push_back(e);
          end
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_load(opcode_e op, int row, int col, logic [ELEM_W-1:0] v);
    mat_cmd_t c;
    c.op  = op;
    c.row = row[IDX_W-1:0];
    c.col = col[IDX_W-1:0];
    c.val = v;
    cmd_q.push_back(c);
    case (op)
      OP_LOAD_A:  a_ok[row * MAX_DIM + col] = 1'b1;
      OP_LOAD_BT: bt_ok[row * MAX_DIM + col] = 1'b1;
      default:    c_ok[row * MAX_DIM + col] = 1'b1;
    endcase
  endtask

  // a compute item, preceded by random loads of whatever it would read unset
  task automatic queue_compute(int row);
    int       n;
    int       rows;
    mat_cmd_t c;
    n    = clamp_dim(cfg_dim);
    rows = clamp_dim(cfg_rows);
    if (n > 0 && row < rows) begin
      for (int k = 0; k < n; k++) begin
        if (!a_ok[row * MAX_DIM + k]) queue_load(OP_LOAD_A, row, k, 16'($urandom));
        if (!c_ok[row * MAX_DIM + k]) queue_load(OP_LOAD_C, row, k, 16'($urandom));
      end
      for (int j = 0; j < n; j++)
        for (int k = 0; k < n; k++)
          if (!bt_ok[j * MAX_DIM + k]) queue_load(OP_LOAD_BT, j, k, 16'($urandom));
    end
    // column and value fields carry junk on a compute item
    c.op  = OP_COMPUTE;
    c.row = row[IDX_W-1:0];
    c.col = IDX_W'($urandom);
    c.val = 16'($urandom);
    cmd_q.push_back(c);
  endtask

  // register write in setup and access cycles, then read it back
  task automatic config_write(reg_idx_e idx, logic [DIM_W-1:0] v);
    logic [APB_D_W-1:0] rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {25'($urandom), v};  // upper bits are not part of the register
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == REG_ROW_COUNT) cfg_rows = v;
    else cfg_dim = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd != {25'b0, v})
      note_failure($sformatf("register %s read 0x%0h, expected 0x%0h", idx.name(), rd, v));
  endtask

  task automatic set_strip(int rows, int dim);
    config_write(REG_ROW_COUNT, rows[DIM_W-1:0]);
    config_write(REG_DIM_SIZE, dim[DIM_W-1:0]);
    @(negedge clk_i);
  endtask

  // block idle: nothing queued, nothing owed, then room for a silent compute
  task automatic wait_drained();
    int n;
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || s_axis_tvalid || pending_elems.size() != 0);
    n = clamp_dim(cfg_dim);
    repeat (n * (n + 5) + 40) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // driver: one item at a time from cmd_q, random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_cmd(drv_cmd);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          drv_cmd = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, drv_cmd.val, drv_cmd.col, drv_cmd.row};
          s_axis_tuser  <= drv_cmd.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare every emitted c element with the oldest one owed
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    c_elem_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_elems.size() == 0) begin
          note_failure($sformatf("unexpected element row %0d col %0d value %0d",
                                 m_axis_tdata[5:0], m_axis_tdata[11:6],
                                 $signed(m_axis_tdata[59:12])));
        end else begin
          want = pending_elems.pop_front();
          if (m_axis_tdata[5:0] != want.row || m_axis_tdata[11:6] != want.col ||
              m_axis_tdata[59:12] != want.value || m_axis_tlast != want.last)
            note_failure($sformatf(
              "expected row %0d col %0d value %0d last %0b, got %0d %0d %0d %0b",
              want.row, want.col, $signed(want.value), want.last,
              m_axis_tdata[5:0], m_axis_tdata[11:6], $signed(m_axis_tdata[59:12]),
              m_axis_tlast));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int      rows;
    int      n;
    int      r;
    int      row_hi;
    opcode_e op;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // sender mostly busy first, then receiver mostly busy, then no gaps
      case (phase * 3 / NUM_PHASES)
        0: begin tx_idle_pct = 22; rx_idle_pct = 62; end
        1: begin tx_idle_pct = 62; rx_idle_pct = 22; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase

      case (phase)
        0: begin
          // full-scale operands, sign extension of c loads, strip edges
          set_strip(4, 3);
          queue_load(OP_LOAD_A, 0, 0, 16'h8000);
          queue_load(OP_LOAD_A, 0, 1, 16'h7fff);
          queue_load(OP_LOAD_A, 0, 2, 16'hffff);
          queue_load(OP_LOAD_BT, 0, 0, 16'h8000);
          queue_load(OP_LOAD_BT, 1, 1, 16'h7fff);
          queue_load(OP_LOAD_BT, 2, 0, 16'h8000);
          queue_load(OP_LOAD_C, 0, 0, 16'h7fff);
          queue_load(OP_LOAD_C, 0, 1, 16'h8000);
          queue_load(OP_LOAD_C, 0, 2, 16'h0000);
          queue_load(OP_LOAD_A, 63, 63, 16'h0000);
          queue_load(OP_LOAD_BT, 63, 63, 16'hffff);
          queue_compute(0);
          queue_compute(0);   // accumulates onto the row just written back
          queue_compute(3);   // last row of the strip
          queue_compute(4);   // first row past the strip
          queue_compute(63);
        end
        1: begin
          // empty strip: every compute is silent
          set_strip(0, 3);
          queue_compute(0);
          queue_compute(63);
        end
        2: begin
          // zero order: every compute is silent
          set_strip(64, 0);
          queue_compute(0);
          queue_compute(63);
        end
        3: begin
          // row count above the maximum clamps to a full strip, order one
          set_strip(127, 1);
          queue_compute(63);
          queue_compute(0);
        end
        4: begin
          // order above the maximum, single-row strip: rows past it stay silent
          set_strip(1, 100);
          queue_compute(1);
          queue_compute(63);
        end
        5: begin
          // full strip, last row
          set_strip(64, 4);
          queue_compute(63);
        end
        default: begin
          // random strips, small orders
          set_strip(($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(1, 8),
                    ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 4));
          rows = clamp_dim(cfg_rows);
          n    = clamp_dim(cfg_dim);
          for (int i = 0; i < RAND_ITEMS; i++) begin
            r  = $urandom_range(99);
            op = opcode_e'($urandom_range(2));
            if (r < 15) begin
              // load anywhere in the stores
              queue_load(op, $urandom_range(63), $urandom_range(63), 16'($urandom));
            end else if (r < 55) begin
              // load inside the area this strip uses
              row_hi = (op == OP_LOAD_BT) ? n : rows;
              if (row_hi == 0 || n == 0)
                queue_load(op, $urandom_range(63), $urandom_range(63), 16'($urandom));
              else
                queue_load(op, $urandom_range(row_hi - 1), $urandom_range(n - 1),
                           16'($urandom));
            end else if (rows == 0 || $urandom_range(4) == 0) begin
              queue_compute($urandom_range(63));
            end else begin
              queue_compute($urandom_range(rows - 1));
            end
          end
        end
      endcase
      wait_drained();
    end

    if (pending_elems.size() != 0)
      note_failure($sformatf("%0d elements never emitted", pending_elems.size()));
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
